### hw/rtl/icmperf_pkg.sv
`timescale 1ns / 1ps

package icmperf_pkg;

    // Default depth of the target MAC table.
    localparam int MAX_TARGETS_DEF = 8;

    // Protocol constants.
    localparam logic [15:0] ETHTYPE_IPV4         = 16'h0800;
    localparam logic [7:0]  IP_PROTO_ICMP        = 8'd1;
    localparam logic [7:0]  ICMP_TYPE_ECHO_REPLY = 8'd0;
    localparam int          MAC_ADDR_LEN         = 6;

    // Byte offsets within the frame.
    localparam logic [6:0] POS_SRC_MAC   = 7'(MAC_ADDR_LEN);
    localparam logic [6:0] POS_ETHERTYPE = 7'(2 * MAC_ADDR_LEN);
    localparam logic [6:0] POS_IHL       = 7'd14;
    localparam logic [6:0] POS_PROTO     = 7'd23;
    localparam logic [6:0] POS_IP_SRC    = 7'd26;
    localparam logic [6:0] POS_IP_DST    = 7'd30;
    localparam logic [6:0] POS_IP_END    = 7'd34;
    localparam logic [6:0] POS_MAX       = 7'd127;

    // Input item kinds carried in tuser.
    localparam logic CMD_FRAME_BYTE = 1'b0;
    localparam logic CMD_LOAD_ENTRY = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_HOST_MAC     = 2'd0;
    localparam logic [1:0] REG_HOST_IP      = 2'd1;
    localparam logic [1:0] REG_TARGET_COUNT = 2'd2;

    // Verdict codes.
    typedef enum logic [2:0] {
        VERDICT_MATCH     = 3'd0,
        VERDICT_SRC       = 3'd1,
        VERDICT_DST       = 3'd2,
        VERDICT_ETHERTYPE = 3'd3,
        VERDICT_IP_DST    = 3'd4,
        VERDICT_PROTO     = 3'd5,
        VERDICT_ICMP_TYPE = 3'd6,
        VERDICT_TRUNCATED = 3'd7
    } verdict_t;

    // Everything the verdict stage needs from one finished frame.
    typedef struct packed {
        logic        ge12;
        logic        ge14;
        logic        ge34;
        logic        dst_ok;
        logic        type_ok;
        logic        ip_dst_ok;
        logic        proto_ok;
        logic        icmp_seen;
        logic        icmp_ok;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
    } frame_summary_t;

    // A table load travelling to the verdict stage.
    typedef struct packed {
        logic        en;
        logic [2:0]  index;
        logic [47:0] mac;
    } table_load_t;

endpackage

### hw/rtl/icmperf_parser.sv
`timescale 1ns / 1ps

module icmperf_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        byte_accept,
    input  logic [7:0]                  frame_byte,
    input  logic                        last_byte,
    input  logic [47:0]                 host_mac,
    input  logic [31:0]                 host_ip,
    input  logic                        advance,
    output logic                        summary_valid,
    output icmperf_pkg::frame_summary_t summary
);
    import icmperf_pkg::*;

    logic [6:0]     pos_reg, pos_next;
    logic           dst_eq_reg, dst_eq_next;
    logic [47:0]    src_mac_reg, src_mac_next;
    logic [15:0]    eth_type_reg, eth_type_next;
    logic [3:0]     ihl_reg, ihl_next;
    logic [7:0]     proto_reg, proto_next;
    logic [31:0]    ip_src_reg, ip_src_next;
    logic           ip_dst_eq_reg, ip_dst_eq_next;
    logic [7:0]     icmp_type_reg, icmp_type_next;
    logic           icmp_seen_reg, icmp_seen_next;
    logic           snap_valid_reg;
    frame_summary_t snap_reg, snap_next;
    logic [7:0]     host_mac_byte;
    logic [7:0]     host_ip_byte;
    logic [1:0]     ip_sel;
    logic [6:0]     icmp_pos;

    // Byte of the own addresses that lines up with the current position.
    assign host_mac_byte = host_mac[{3'd5 - pos_reg[2:0], 3'b000} +: 8];
    assign ip_sel        = 2'(7'd33 - pos_reg);
    assign host_ip_byte  = host_ip[{ip_sel, 3'b000} +: 8];

    // Field capture for the byte at the current position.
    always_comb begin
        pos_next       = (pos_reg < POS_MAX) ? pos_reg + 7'd1 : pos_reg;
        dst_eq_next    = dst_eq_reg;
        src_mac_next   = src_mac_reg;
        eth_type_next  = eth_type_reg;
        ihl_next       = ihl_reg;
        proto_next     = proto_reg;
        ip_src_next    = ip_src_reg;
        ip_dst_eq_next = ip_dst_eq_reg;
        icmp_type_next = icmp_type_reg;
        icmp_seen_next = icmp_seen_reg;
        if (pos_reg < POS_SRC_MAC) begin
            dst_eq_next = dst_eq_reg & (host_mac_byte == frame_byte);
        end else if (pos_reg < POS_ETHERTYPE) begin
            src_mac_next = {src_mac_reg[39:0], frame_byte};
        end else if (pos_reg < POS_IHL) begin
            eth_type_next = {eth_type_reg[7:0], frame_byte};
        end else if (pos_reg == POS_IHL) begin
            ihl_next = frame_byte[3:0];
        end else if (pos_reg == POS_PROTO) begin
            proto_next = frame_byte;
        end else if (pos_reg >= POS_IP_SRC && pos_reg < POS_IP_DST) begin
            ip_src_next = {ip_src_reg[23:0], frame_byte};
        end else if (pos_reg >= POS_IP_DST && pos_reg < POS_IP_END) begin
            ip_dst_eq_next = ip_dst_eq_reg & (host_ip_byte == frame_byte);
        end
        // The ICMP type sits right after the IP header, with IHL as just seen.
        icmp_pos = POS_IHL + {1'b0, ihl_next, 2'b00};
        if (pos_reg >= POS_IHL && pos_reg == icmp_pos) begin
            icmp_type_next = frame_byte;
            icmp_seen_next = 1'b1;
        end
    end

    // Summary of the frame as it stands after the last byte.
    always_comb begin
        snap_next.ge12      = pos_reg >= 7'd11;
        snap_next.ge14      = pos_reg >= 7'd13;
        snap_next.ge34      = pos_reg >= 7'd33;
        snap_next.dst_ok    = dst_eq_next;
        snap_next.type_ok   = eth_type_next == ETHTYPE_IPV4;
        snap_next.ip_dst_ok = ip_dst_eq_next;
        snap_next.proto_ok  = proto_next == IP_PROTO_ICMP;
        snap_next.icmp_seen = icmp_seen_next;
        snap_next.icmp_ok   = icmp_type_next == ICMP_TYPE_ECHO_REPLY;
        snap_next.src_mac   = src_mac_next;
        snap_next.src_ip    = ip_src_next;
    end

    // Frame state; it returns to its idle values after each last byte.
    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_accept && last_byte)) begin
            pos_reg       <= '0;
            dst_eq_reg    <= 1'b1;
            src_mac_reg   <= '0;
            eth_type_reg  <= '0;
            ihl_reg       <= '0;
            proto_reg     <= '0;
            ip_src_reg    <= '0;
            ip_dst_eq_reg <= 1'b1;
            icmp_type_reg <= '0;
            icmp_seen_reg <= 1'b0;
        end else if (byte_accept) begin
            pos_reg       <= pos_next;
            dst_eq_reg    <= dst_eq_next;
            src_mac_reg   <= src_mac_next;
            eth_type_reg  <= eth_type_next;
            ihl_reg       <= ihl_next;
            proto_reg     <= proto_next;
            ip_src_reg    <= ip_src_next;
            ip_dst_eq_reg <= ip_dst_eq_next;
            icmp_type_reg <= icmp_type_next;
            icmp_seen_reg <= icmp_seen_next;
        end
    end

    // Summary register handed to the verdict stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (byte_accept && last_byte) begin
            snap_valid_reg <= 1'b1;
        end else if (advance) begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_accept && last_byte) begin
            snap_reg <= snap_next;
        end
    end

    assign summary_valid = snap_valid_reg;
    assign summary       = snap_reg;

    // A frame's last byte leaves the parser ready for a new frame.
    a_pos_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_accept && last_byte |=> pos_reg == '0 && dst_eq_reg && !icmp_seen_reg)
        else $error("frame state not cleared after last byte");

    // The position counter never moves without an accepted frame byte.
    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !byte_accept |=> $stable(pos_reg))
        else $error("byte position moved without a frame byte");

    // The ICMP type is never seen before the IHL byte.
    a_icmp_after_ihl: assert property (@(posedge aclk) disable iff (!aresetn)
        icmp_seen_reg |-> pos_reg > POS_IHL)
        else $error("ICMP type captured before the IP header");

endmodule

### hw/rtl/icmperf_judge.sv
`timescale 1ns / 1ps

module icmperf_judge #(
    parameter int MAX_TARGETS = icmperf_pkg::MAX_TARGETS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  icmperf_pkg::table_load_t    load,
    input  logic [3:0]                  target_count,
    input  logic                        summary_valid,
    input  icmperf_pkg::frame_summary_t summary,
    output logic                        advance,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [87:0]                 m_tdata
);
    import icmperf_pkg::*;

    localparam int TIDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;

    logic [47:0] table_mem [MAX_TARGETS];
    logic        src_known;
    verdict_t    verdict_next;
    logic        out_valid_reg;
    verdict_t    verdict_reg;
    logic [47:0] mac_reg;
    logic [31:0] ip_reg;

    // Target table loads; a slot beyond the table is dropped.
    always_ff @(posedge aclk) begin
        if (load.en && (32'(load.index) < MAX_TARGETS)) begin
            table_mem[TIDX_W'(load.index)] <= load.mac;
        end
    end

    // Source lookup over the first target_count entries.
    always_comb begin
        src_known = 1'b0;
        for (int i = 0; i < MAX_TARGETS; i++) begin
            if ((32'(i) < 32'(target_count)) && (table_mem[i] == summary.src_mac)) begin
                src_known = 1'b1;
            end
        end
    end

    // Checks in verdict order; missing bytes give a truncated verdict.
    always_comb begin
        priority if (!summary.ge12) begin
            verdict_next = VERDICT_TRUNCATED;
        end else if (!src_known) begin
            verdict_next = VERDICT_SRC;
        end else if (!summary.dst_ok) begin
            verdict_next = VERDICT_DST;
        end else if (!summary.ge14) begin
            verdict_next = VERDICT_TRUNCATED;
        end else if (!summary.type_ok) begin
            verdict_next = VERDICT_ETHERTYPE;
        end else if (!summary.ge34) begin
            verdict_next = VERDICT_TRUNCATED;
        end else if (!summary.ip_dst_ok) begin
            verdict_next = VERDICT_IP_DST;
        end else if (!summary.proto_ok) begin
            verdict_next = VERDICT_PROTO;
        end else if (!summary.icmp_seen) begin
            verdict_next = VERDICT_TRUNCATED;
        end else if (!summary.icmp_ok) begin
            verdict_next = VERDICT_ICMP_TYPE;
        end else begin
            verdict_next = VERDICT_MATCH;
        end
    end

    // Result register; it moves whenever it is empty or being taken.
    assign advance = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= summary_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && summary_valid) begin
            verdict_reg <= verdict_next;
            mac_reg     <= (verdict_next == VERDICT_MATCH) ? summary.src_mac : '0;
            ip_reg      <= (verdict_next == VERDICT_MATCH) ? summary.src_ip : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, ip_reg, mac_reg, verdict_reg};

    // Address fields are zero on every verdict but a match.
    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && verdict_reg != VERDICT_MATCH |-> mac_reg == '0 && ip_reg == '0)
        else $error("address fields set on a failing verdict");

    // A waiting summary is moved into an empty result register.
    a_summary_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        summary_valid && !out_valid_reg |=> out_valid_reg)
        else $error("summary not moved into the result register");

    // A stalled result is held until it is taken.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(verdict_reg))
        else $error("stalled result changed");

endmodule

### hw/rtl/icmp_echo_reply_frame_filter.sv
`timescale 1ns / 1ps

// ICMP echo-reply frame filter.
// The input stream carries one item per transfer: with s_tuser low, s_tdata[7:0] is
// the next received frame byte (starting at the destination MAC) and s_tlast marks
// the frame's last byte; with s_tuser high, the item loads the target MAC in
// s_tdata[58:11] into table slot s_tdata[10:8]. Loads produce no result.
// Each frame yields exactly one result transfer on the m_ stream: a verdict code
// and, for a match, the frame's source MAC and source IPv4 address.
// The configuration port writes host_mac, host_ip and target_count; the user must see that
// writes are made only while no frame is in flight, as the block does not enforce it.
// Throughput is one input transfer per cycle while s_tready is high. The result of a
// frame passes from the parser's summary register into the verdict register before
// it appears on m_tvalid.
// When the receiver stalls, the result register holds its transfer and the
// summary register takes the next finished frame; input stalls only when both
// are full. Reset clears the frame state, the configuration and both stages;
// the target table keeps no reset value and must be loaded before use.
module icmp_echo_reply_frame_filter #(
    parameter int MAX_TARGETS = icmperf_pkg::MAX_TARGETS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // frame_byte[7:0], entry_index[10:8], entry_mac[58:11]
    input  logic        s_tlast,   // last_byte
    input  logic        s_tuser,   // cmd
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // verdict[2:0], matched_mac[50:3], source_ip[82:51]
    // Configuration writes.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_wdata
);
    import icmperf_pkg::*;

    logic           s_accept;
    logic           byte_accept;
    logic           advance;
    logic           summary_valid;
    frame_summary_t summary;
    table_load_t    load;
    logic [47:0]    host_mac_reg;
    logic [31:0]    host_ip_reg;
    logic [3:0]     target_count_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            host_mac_reg     <= '0;
            host_ip_reg      <= '0;
            target_count_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_HOST_MAC:     host_mac_reg     <= cfg_wdata;
                REG_HOST_IP:      host_ip_reg      <= cfg_wdata[31:0];
                REG_TARGET_COUNT: target_count_reg <= cfg_wdata[3:0];
                default:          ;
            endcase
        end
    end

    // Input is taken unless a finished frame is waiting behind a stalled result.
    assign s_tready    = !summary_valid || advance;
    assign s_accept    = s_tvalid && s_tready;
    assign byte_accept = s_accept && (s_tuser == CMD_FRAME_BYTE);

    assign load.en    = s_accept && (s_tuser == CMD_LOAD_ENTRY);
    assign load.index = s_tdata[10:8];
    assign load.mac   = s_tdata[58:11];

    icmperf_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .byte_accept   (byte_accept),
        .frame_byte    (s_tdata[7:0]),
        .last_byte     (s_tlast),
        .host_mac      (host_mac_reg),
        .host_ip       (host_ip_reg),
        .advance       (advance),
        .summary_valid (summary_valid),
        .summary       (summary)
    );

    icmperf_judge #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_judge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (load),
        .target_count  (target_count_reg),
        .summary_valid (summary_valid),
        .summary       (summary),
        .advance       (advance),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule
